@@ hw/rtl/assert_macros.svh @@
// Shared assertion shorthands for the walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_AT(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clock, reset_n, cond, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) !(cond)) \
        else $error(msg);

`endif

@@ hw/rtl/ptw_pkg.sv @@
`default_nettype none

package ptw_pkg;

    // Input command codes
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_ENTRY     = 1'b1;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Walk status codes
    localparam logic [1:0] ST_MAPPED_4K   = 2'd0;
    localparam logic [1:0] ST_LARGE_2M    = 2'd1;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd2;
    localparam logic [1:0] ST_ZERO_ADDR   = 2'd3;

    // Table levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDP  = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PML4_BASE = 2'd0;
    localparam logic [1:0] CFG_PDP_BASE  = 2'd1;
    localparam logic [1:0] CFG_PD_BASE   = 2'd2;
    localparam logic [1:0] CFG_PT_BASE   = 2'd3;

    // Present and page-size bits of a large directory entry
    localparam logic [63:0] LARGE_MASK = 64'h81;

    localparam int PHYS_W = 41;

    // Work handed from the front to the back
    typedef enum logic [2:0] {
        OP_RD_PML4,
        OP_RD_PDP,
        OP_RD_PD,
        OP_RD_PT,
        OP_FIN_ZERO,
        OP_FIN_ABSENT,
        OP_FIN_LARGE,
        OP_FIN_4K
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  level;
        logic [63:0] va;
    } job_t;

    typedef struct packed {
        logic              kind;
        logic [63:0]       read_addr;
        logic [1:0]        status;
        logic [1:0]        fault_level;
        logic [PHYS_W-1:0] phys_addr;
        logic [63:0]       pte_addr;
    } result_t;

    // Byte offset of the entry for va inside the self-mapped window of a level
    function automatic logic [63:0] entry_offset(op_t op, logic [63:0] va);
        logic [63:0] off;
        case (op)
            OP_RD_PML4: off = {52'd0, va[47:39], 3'd0};
            OP_RD_PDP:  off = {43'd0, va[47:30], 3'd0};
            OP_RD_PD:   off = {34'd0, va[47:21], 3'd0};
            default:    off = {25'd0, va[47:12], 3'd0};
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ptw_fifo.sv @@
`default_nettype none

module ptw_fifo
    #(
        parameter int WIDTH = 8
    )
    (
        input  wire logic             clk,
        input  wire logic             rst_n,
        input  wire logic             push,
        input  wire logic [WIDTH-1:0] wdata,
        output logic                  full,
        input  wire logic             pop,
        output logic [WIDTH-1:0]      rdata,
        output logic                  empty
    );

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry on transfer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ptw_front.sv @@
`default_nettype none
`include "assert_macros.svh"

module ptw_front
    import ptw_pkg::*;
    (
        input  wire logic        clk,
        input  wire logic        rst_n,
        input  wire logic        accept,
        input  wire logic        cmd,
        input  wire logic [63:0] virt_addr,
        input  wire logic [63:0] entry_word,
        output logic             job_valid,
        output job_t             job
    );

    logic        busy_reg;
    logic        busy_next;
    logic [1:0]  level_reg;
    logic [1:0]  level_next;
    logic [63:0] vaddr_reg;
    logic [63:0] vaddr_next;

    // Classify the transfer and step the walk state
    always_comb
    begin
        job_valid  = 1'b0;
        job.op     = OP_RD_PML4;
        job.level  = level_reg;
        job.va     = vaddr_reg;
        busy_next  = busy_reg;
        level_next = level_reg;
        vaddr_next = vaddr_reg;
        if (accept)
        begin
            if (cmd == CMD_TRANSLATE)
            begin
                job_valid  = 1'b1;
                job.va     = virt_addr;
                level_next = LVL_PML4;
                if (virt_addr == 64'd0)
                begin
                    job.op    = OP_FIN_ZERO;
                    busy_next = 1'b0;
                end
                else
                begin
                    job.op     = OP_RD_PML4;
                    busy_next  = 1'b1;
                    vaddr_next = virt_addr;
                end
            end
            else if (busy_reg)
            begin
                job_valid = 1'b1;
                if (!entry_word[0])
                begin
                    job.op     = OP_FIN_ABSENT;
                    busy_next  = 1'b0;
                    level_next = LVL_PML4;
                end
                else
                begin
                    case (level_reg)
                        LVL_PML4:
                        begin
                            job.op     = OP_RD_PDP;
                            level_next = LVL_PDP;
                        end
                        LVL_PDP:
                        begin
                            job.op     = OP_RD_PD;
                            level_next = LVL_PD;
                        end
                        LVL_PD:
                        begin
                            if ((entry_word & LARGE_MASK) == LARGE_MASK)
                            begin
                                job.op     = OP_FIN_LARGE;
                                busy_next  = 1'b0;
                                level_next = LVL_PML4;
                            end
                            else
                            begin
                                job.op     = OP_RD_PT;
                                level_next = LVL_PT;
                            end
                        end
                        default:
                        begin
                            job.op     = OP_FIN_4K;
                            busy_next  = 1'b0;
                            level_next = LVL_PML4;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            level_reg <= LVL_PML4;
            vaddr_reg <= 64'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            vaddr_reg <= vaddr_next;
        end
    end

    `ASSERT_NEVER(a_level_only_when_busy, clk, rst_n, (level_reg != LVL_PML4) && !busy_reg,
        "walk level advanced with no walk in progress")
    `ASSERT_AT(a_start_walk, clk, rst_n,
        accept && (cmd == CMD_TRANSLATE) && (virt_addr != 64'd0)
            |=> busy_reg && (level_reg == LVL_PML4) && (vaddr_reg == $past(virt_addr)),
        "translate request did not start a walk")
    `ASSERT_AT(a_finish_idles, clk, rst_n,
        job_valid && ((job.op == OP_FIN_ABSENT) || (job.op == OP_FIN_LARGE)
            || (job.op == OP_FIN_4K) || (job.op == OP_FIN_ZERO)) |=> !busy_reg,
        "walk still busy after finishing")

endmodule

`default_nettype wire

@@ hw/rtl/ptw_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module ptw_back
    import ptw_pkg::*;
    #(
        parameter int PHYS_FRAME_BITS = 28
    )
    (
        input  wire logic                       clk,
        input  wire logic                       rst_n,
        input  wire logic                       cfg_write,
        input  wire logic [1:0]                 cfg_index,
        input  wire logic [63:0]                cfg_data,
        input  wire logic                       job_valid,
        input  wire job_t                       job,
        input  wire logic [PHYS_FRAME_BITS-1:0] frame,
        output logic                            job_take,
        input  wire logic                       res_room,
        output logic                            res_valid,
        output result_t                         res
    );

    logic [63:0] pml4_base_reg;
    logic [63:0] pdp_base_reg;
    logic [63:0] pd_base_reg;
    logic [63:0] pt_base_reg;
    logic [63:0] base_sel;
    logic [63:0] entry_addr;
    logic [63:0] frame_ext;
    logic [63:0] page_4k;
    logic [63:0] page_2m;

    // Hold window bases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pml4_base_reg <= 64'd0;
            pdp_base_reg  <= 64'd0;
            pd_base_reg   <= 64'd0;
            pt_base_reg   <= 64'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PML4_BASE: pml4_base_reg <= cfg_data;
                CFG_PDP_BASE:  pdp_base_reg  <= cfg_data;
                CFG_PD_BASE:   pd_base_reg   <= cfg_data;
                CFG_PT_BASE:   pt_base_reg   <= cfg_data;
                default:       pt_base_reg   <= pt_base_reg;
            endcase
        end
    end

    assign job_take  = job_valid && res_room;
    assign res_valid = job_take;

    // Entry address: window offset plus base of the level
    always_comb
    begin
        case (job.op)
            OP_RD_PML4: base_sel = pml4_base_reg;
            OP_RD_PDP:  base_sel = pdp_base_reg;
            OP_RD_PD:   base_sel = pd_base_reg;
            default:    base_sel = pt_base_reg;
        endcase
    end

    assign entry_addr = entry_offset(job.op, job.va) + base_sel;

    // Physical addresses for small and large pages
    assign frame_ext = {{(64 - PHYS_FRAME_BITS){1'b0}}, frame};
    assign page_4k   = (frame_ext << 12) | {52'd0, job.va[11:0]};
    assign page_2m   = ((frame_ext & ~64'h1ff) << 12) | {43'd0, job.va[20:0]};

    // Build the result; unused fields stay zero
    always_comb
    begin
        res.kind        = KIND_READ;
        res.read_addr   = 64'd0;
        res.status      = ST_MAPPED_4K;
        res.fault_level = LVL_PML4;
        res.phys_addr   = '0;
        res.pte_addr    = 64'd0;
        case (job.op)
            OP_RD_PML4, OP_RD_PDP, OP_RD_PD, OP_RD_PT:
            begin
                res.read_addr = entry_addr;
            end
            OP_FIN_ZERO:
            begin
                res.kind   = KIND_DONE;
                res.status = ST_ZERO_ADDR;
            end
            OP_FIN_ABSENT:
            begin
                res.kind        = KIND_DONE;
                res.status      = ST_NOT_PRESENT;
                res.fault_level = job.level;
            end
            OP_FIN_LARGE:
            begin
                res.kind      = KIND_DONE;
                res.status    = ST_LARGE_2M;
                res.phys_addr = page_2m[PHYS_W-1:0];
            end
            default:
            begin
                res.kind      = KIND_DONE;
                res.status    = ST_MAPPED_4K;
                res.phys_addr = page_4k[PHYS_W-1:0];
                res.pte_addr  = entry_addr;
            end
        endcase
    end

    `ASSERT_AT(a_read_fields_clear, clk, rst_n,
        res_valid && (res.kind == KIND_READ)
            |-> (res.status == ST_MAPPED_4K) && (res.pte_addr == 64'd0),
        "read request carries completion fields")

endmodule

`default_nettype wire

@@ hw/rtl/page_table_walker.sv @@
// Four-level page table walker over a recursive self-map. Push a translate
// request (cmd 0) or a returned table entry (cmd 1); each transfer yields at
// most one result: a read request for the next entry or a finished walk.
// The block takes one item every cycle while full is low and delivers one
// result every cycle while pop is high and empty is low. Classification is
// combinational and lands in a two-entry job queue at the transfer edge;
// the address add moves the job into a two-entry result queue when that
// queue has room. With pop held low, four result-producing items fill the
// two queues before full rises. A returned entry with no walk in progress
// is dropped without a result. A new translate request abandons any walk in
// progress. Write the window bases only while the block is idle.
`default_nettype none

module page_table_walker
    import ptw_pkg::*;
    #(
        parameter int PHYS_FRAME_BITS = 28
    )
    (
        input  wire logic        clk,
        input  wire logic        rst_n,
        input  wire logic        push,
        output logic             full,
        input  wire logic        cmd,
        input  wire logic [63:0] virt_addr,
        input  wire logic [63:0] entry_word,
        output logic             empty,
        input  wire logic        pop,
        output logic             kind,
        output logic [63:0]      read_addr,
        output logic [1:0]       status,
        output logic [1:0]       fault_level,
        output logic [40:0]      phys_addr,
        output logic [63:0]      pte_addr,
        input  wire logic        cfg_write,
        input  wire logic [1:0]  cfg_index,
        input  wire logic [63:0] cfg_data
    );

    localparam int JOB_W = $bits(job_t);
    localparam int MID_W = JOB_W + PHYS_FRAME_BITS;
    localparam int RES_W = $bits(result_t);

    logic                       accept;
    logic                       fr_valid;
    job_t                       fr_job;
    logic [MID_W-1:0]           mid_wdata;
    logic [MID_W-1:0]           mid_rdata;
    logic                       mid_empty;
    job_t                       bk_job;
    logic [PHYS_FRAME_BITS-1:0] bk_frame;
    logic                       bk_take;
    logic                       res_valid;
    result_t                    res;
    logic                       out_full;
    logic [RES_W-1:0]           out_rdata;
    result_t                    out_res;

    assign accept = push && !full;

    // Classify transfers and track the walk
    ptw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (cmd),
        .virt_addr  (virt_addr),
        .entry_word (entry_word),
        .job_valid  (fr_valid),
        .job        (fr_job)
    );

    assign mid_wdata = {fr_job, entry_word[12 +: PHYS_FRAME_BITS]};

    // Job queue between front and back
    ptw_fifo #(
        .WIDTH (MID_W)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_valid),
        .wdata (mid_wdata),
        .full  (full),
        .pop   (bk_take),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign bk_job   = mid_rdata[MID_W-1 -: JOB_W];
    assign bk_frame = mid_rdata[PHYS_FRAME_BITS-1:0];

    // Form read requests and completions
    ptw_back #(
        .PHYS_FRAME_BITS (PHYS_FRAME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (!mid_empty),
        .job       (bk_job),
        .frame     (bk_frame),
        .job_take  (bk_take),
        .res_room  (!out_full),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result queue toward the consumer
    ptw_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata (res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign out_res     = out_rdata;
    assign kind        = out_res.kind;
    assign read_addr   = out_res.read_addr;
    assign status      = out_res.status;
    assign fault_level = out_res.fault_level;
    assign phys_addr   = out_res.phys_addr;
    assign pte_addr    = out_res.pte_addr;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none

module testbench
    import ptw_pkg::*;
    ();

    localparam int FRAME_BITS = 28;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FRAME_MASK = (64'd1 << FRAME_BITS) - 64'd1;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_RESULTS = 430;

    // Predicts walk results and checks them in order of arrival
    class walk_tracker;
        logic [63:0] base [4];
        bit          busy;
        logic [1:0]  level;
        logic [63:0] walk_va;
        result_t     awaited [$];
        int          predicted;
        int          checked;
        int          fail_count;
        int          dropped;
        int          reads;
        int          settings;
        int          done_by_status [4];
        int          fault_by_level [4];

        function new();
            for (int i = 0; i < 4; i++)
            begin
                base[i] = '0;
                done_by_status[i] = 0;
                fault_by_level[i] = 0;
            end
            busy = 1'b0;
            level = LVL_PML4;
            walk_va = '0;
            predicted = 0;
            checked = 0;
            fail_count = 0;
            dropped = 0;
            reads = 0;
            settings = 0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // Advance the walk by one accepted transfer and queue its result, if any
        function void note_transfer(logic c, logic [63:0] va, logic [63:0] e);
            result_t     r;
            logic [63:0] frame;
            logic [63:0] pa;
            r = '0;
            if (c == CMD_TRANSLATE)
            begin
                if (va == 64'd0)
                begin
                    busy = 1'b0;
                    level = LVL_PML4;
                    r.kind = KIND_DONE;
                    r.status = ST_ZERO_ADDR;
                end
                else
                begin
                    walk_va = va;
                    busy = 1'b1;
                    level = LVL_PML4;
                    r.kind = KIND_READ;
                    r.read_addr = ((va >> 36) & 64'hff8) + base[CFG_PML4_BASE];
                end
            end
            else if (!busy)
            begin
                dropped++;
                return;
            end
            else if (!e[0])
            begin
                r.kind = KIND_DONE;
                r.status = ST_NOT_PRESENT;
                r.fault_level = level;
                fault_by_level[level]++;
                busy = 1'b0;
                level = LVL_PML4;
            end
            else
            begin
                frame = (e >> 12) & FRAME_MASK;
                case (level)
                    LVL_PML4:
                    begin
                        level = LVL_PDP;
                        r.kind = KIND_READ;
                        r.read_addr = ((walk_va >> 27) & 64'h1ffff8) + base[CFG_PDP_BASE];
                    end
                    LVL_PDP:
                    begin
                        level = LVL_PD;
                        r.kind = KIND_READ;
                        r.read_addr = ((walk_va >> 18) & 64'h3ffffff8) + base[CFG_PD_BASE];
                    end
                    LVL_PD:
                    begin
                        if ((e & LARGE_MASK) == LARGE_MASK)
                        begin
                            // PAT bit and the rest of the low frame bits come from the address
                            frame = (frame & ~64'h1ff) | ((walk_va >> 12) & 64'h1ff);
                            pa = (frame << 12) + (walk_va & 64'hfff);
                            r.kind = KIND_DONE;
                            r.status = ST_LARGE_2M;
                            r.phys_addr = pa[PHYS_W-1:0];
                            busy = 1'b0;
                            level = LVL_PML4;
                        end
                        else
                        begin
                            level = LVL_PT;
                            r.kind = KIND_READ;
                            r.read_addr = ((walk_va >> 9) & 64'h7ffffffff8)
                                        + base[CFG_PT_BASE];
                        end
                    end
                    default:
                    begin
                        pa = (frame << 12) + (walk_va & 64'hfff);
                        r.kind = KIND_DONE;
                        r.status = ST_MAPPED_4K;
                        r.phys_addr = pa[PHYS_W-1:0];
                        r.pte_addr = ((walk_va >> 9) & 64'h7ffffffff8) + base[CFG_PT_BASE];
                        busy = 1'b0;
                        level = LVL_PML4;
                    end
                endcase
            end
            if (r.kind == KIND_READ)
                reads++;
            else
                done_by_status[r.status]++;
            predicted++;
            awaited.push_back(r);
        endfunction

        // Compare one delivered result with the oldest prediction
        function void compare_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected result: kind %0d read_addr %h status %0d",
                             got.kind, got.read_addr, got.status);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.kind !== want.kind || got.read_addr !== want.read_addr
                || got.status !== want.status || got.fault_level !== want.fault_level
                || got.phys_addr !== want.phys_addr || got.pte_addr !== want.pte_addr)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("Result %0d mismatch", checked);
                    $display("  expected kind %0d read %h status %0d level %0d phys %h pte %h",
                             want.kind, want.read_addr, want.status, want.fault_level,
                             want.phys_addr, want.pte_addr);
                    $display("  actual   kind %0d read %h status %0d level %0d phys %h pte %h",
                             got.kind, got.read_addr, got.status, got.fault_level,
                             got.phys_addr, got.pte_addr);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        cmd;
    logic [63:0] virt_addr;
    logic [63:0] entry_word;
    logic        empty;
    logic        pop;
    logic        kind;
    logic [63:0] read_addr;
    logic [1:0]  status;
    logic [1:0]  fault_level;
    logic [40:0] phys_addr;
    logic [63:0] pte_addr;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    walk_tracker book = new();
    bit          calm = 1'b0;
    int          rx_hold = 0;

    page_table_walker #(.PHYS_FRAME_BITS(FRAME_BITS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .virt_addr   (virt_addr),
        .entry_word  (entry_word),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .read_addr   (read_addr),
        .status      (status),
        .fault_level (fault_level),
        .phys_addr   (phys_addr),
        .pte_addr    (pte_addr),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Half of the addresses are canonical, sign-extended from bit 47
    function automatic logic [63:0] rand_va();
        logic [63:0] w;
        w = rand_word();
        if ($urandom_range(1) == 0)
            w = {{16{w[47]}}, w[47:0]};
        return w;
    endfunction

    // Offer one item, idling now and then, and hold it until the transfer
    task automatic send_item(logic c, logic [63:0] va, logic [63:0] e);
        while (!calm && $urandom_range(99) < 11)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        cmd <= c;
        virt_addr <= va;
        entry_word <= e;
        @(posedge clk);
        while (full)
            @(posedge clk);
        book.note_transfer(c, va, e);
    endtask

    // Stop offering and wait until every predicted result has been delivered
    task automatic drain();
        push <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bases(logic [63:0] b0, logic [63:0] b1,
                               logic [63:0] b2, logic [63:0] b3);
        cfg_write <= 1'b1;
        cfg_index <= CFG_PML4_BASE;
        cfg_data <= b0;
        @(posedge clk);
        cfg_index <= CFG_PDP_BASE;
        cfg_data <= b1;
        @(posedge clk);
        cfg_index <= CFG_PD_BASE;
        cfg_data <= b2;
        @(posedge clk);
        cfg_index <= CFG_PT_BASE;
        cfg_data <= b3;
        @(posedge clk);
        cfg_write <= 1'b0;
        book.base[CFG_PML4_BASE] = b0;
        book.base[CFG_PDP_BASE] = b1;
        book.base[CFG_PD_BASE] = b2;
        book.base[CFG_PT_BASE] = b3;
        book.settings++;
    endtask

    // Stimulus
    initial
    begin
        int          pick;
        int          fault_at;
        int          lvl;
        int          phase;
        int          next_switch;
        int          calm_until;
        bit          big_page;
        logic [63:0] ent;

        rst_n <= 1'b0;
        push <= 1'b0;
        cmd <= CMD_TRANSLATE;
        virt_addr <= '0;
        entry_word <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_PML4_BASE;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-ones bases make every entry address with a nonzero offset wrap
        write_bases(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);

        // Stray entry before any walk: dropped
        send_item(CMD_ENTRY, rand_word(), ALL_ONES);
        // Zero address finishes at once
        send_item(CMD_TRANSLATE, '0, rand_word());
        // All-ones address and entries end as a large page
        send_item(CMD_TRANSLATE, ALL_ONES, rand_word());
        repeat (3) send_item(CMD_ENTRY, rand_word(), ALL_ONES);
        // Smallest present entries, all-ones leaf: 4K page
        send_item(CMD_TRANSLATE, 64'h1, rand_word());
        repeat (3) send_item(CMD_ENTRY, rand_word(), 64'h1);
        send_item(CMD_ENTRY, rand_word(), ALL_ONES);
        // Absent directory pointer entry
        send_item(CMD_TRANSLATE, 64'h0000_7FFF_FFFF_F000, rand_word());
        send_item(CMD_ENTRY, rand_word(), ALL_ONES);
        send_item(CMD_ENTRY, rand_word(), 64'h0);
        // Size bit without present bit at the directory level
        send_item(CMD_TRANSLATE, rand_va(), rand_word());
        repeat (2) send_item(CMD_ENTRY, rand_word(), 64'h1);
        send_item(CMD_ENTRY, rand_word(), 64'h80);
        // Absent leaf entry with every other bit set
        send_item(CMD_TRANSLATE, 64'h8000_0000_0000_0000, rand_word());
        repeat (3) send_item(CMD_ENTRY, rand_word(), 64'h1);
        send_item(CMD_ENTRY, rand_word(), 64'hFFFF_FFFF_FFFF_FFFE);
        // New request while busy abandons the walk
        send_item(CMD_TRANSLATE, rand_va(), rand_word());
        send_item(CMD_ENTRY, rand_word(), 64'h1);
        send_item(CMD_TRANSLATE, rand_va(), rand_word());
        send_item(CMD_ENTRY, rand_word(), 64'h0);
        drain();

        phase = 0;
        next_switch = book.predicted + 90;
        calm_until = 0;
        while (book.predicted < RANDOM_RESULTS)
        begin
            // Switch window bases between phases, with the block drained
            if (book.predicted >= next_switch && phase < 4)
            begin
                drain();
                phase++;
                next_switch = book.predicted + 90;
                case (phase)
                    1: write_bases('0, '0, '0, '0);
                    2: write_bases(64'hFFFF_F6FB_7DBE_D000, 64'hFFFF_F6FB_7DA0_0000,
                                   64'hFFFF_F6FB_4000_0000, 64'hFFFF_F680_0000_0000);
                    3: write_bases(rand_word(), rand_word(), rand_word(), rand_word());
                    default: write_bases(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                                         rand_word(), 64'h1);
                endcase
                if (phase == 1)
                begin
                    // Back-pressure: hold the sink while pushing without gaps
                    calm = 1'b1;
                    rx_hold = 80;
                    calm_until = book.predicted + 60;
                end
            end
            if (calm && book.predicted >= calm_until)
                calm = 1'b0;

            pick = $urandom_range(99);
            if (pick < 72)
            begin
                // Well-formed walk, sometimes ending on an absent entry
                fault_at = ($urandom_range(99) < 20) ? $urandom_range(3) : 4;
                big_page = ($urandom_range(99) < 35);
                send_item(CMD_TRANSLATE, rand_va(), rand_word());
                for (lvl = 0; lvl < 4; lvl++)
                begin
                    ent = rand_word();
                    ent[0] = (lvl != fault_at);
                    if (lvl == 2)
                        ent[7] = big_page;
                    send_item(CMD_ENTRY, rand_word(), ent);
                    if (lvl == fault_at || (lvl == 2 && big_page))
                        break;
                end
            end
            else if (pick < 84)
            begin
                // Walk left unfinished; later entries may go on with it, else the next request abandons it
                send_item(CMD_TRANSLATE, rand_va(), rand_word());
                repeat ($urandom_range(3))
                begin
                    ent = rand_word();
                    ent[0] = 1'b1;
                    ent[7] = 1'b0;
                    send_item(CMD_ENTRY, rand_word(), ent);
                end
            end
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 3))
                    send_item(CMD_ENTRY, rand_word(), rand_word());
            end
            else
                send_item(CMD_TRANSLATE, '0, rand_word());
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Checked %0d results: %0d reads, 4K %0d, 2M %0d, absent %0d, zero %0d",
                 book.checked, book.reads, book.done_by_status[ST_MAPPED_4K],
                 book.done_by_status[ST_LARGE_2M], book.done_by_status[ST_NOT_PRESENT],
                 book.done_by_status[ST_ZERO_ADDR]);
        $display("Absent at pml4/pdp/pd/pt %0d/%0d/%0d/%0d, %0d dropped, %0d base settings",
                 book.fault_by_level[LVL_PML4], book.fault_by_level[LVL_PDP],
                 book.fault_by_level[LVL_PD], book.fault_by_level[LVL_PT],
                 book.dropped, book.settings);
        if (book.fail_count == 0 && book.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result sink: check each transfer, stall at random or for a long hold
    initial
    begin : result_sink
        result_t got;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.kind = kind;
                got.read_addr = read_addr;
                got.status = status;
                got.fault_level = fault_level;
                got.phys_addr = phys_addr;
                got.pte_addr = pte_addr;
                book.compare_result(got);
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else
                pop <= calm || ($urandom_range(99) >= 11);
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", quiet);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
